[design/pts_pkg.sv]
package pts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  // widest task index over the supported table sizes (up to 64 entries)
  localparam int unsigned IDX_W_MAX = 6;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_DELAY  = 3'd2,
    OP_TICK   = 3'd3,
    OP_SWITCH = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARAM   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_BLOCKED = 2'd1,
    TS_RUNNING = 2'd2
  } task_state_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CREATE,
    CELL_WAKE,
    CELL_BLOCK,
    CELL_APPLY
  } cell_op_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_APPLY,
    FSM_OUT
  } fsm_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W_MAX-1:0]   target;
    logic [7:0]             prio;
    logic [31:0]            value;
    logic                   demote_en;
    logic [IDX_W_MAX-1:0]   demote;
  } cell_cmd_t;

  // best candidate handed along the row
  typedef struct packed {
    logic                   found;
    logic [7:0]             prio;
    logic [IDX_W_MAX-1:0]   idx;
  } carry_t;

endpackage

[design/pts_cell.sv]
module pts_cell import pts_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      in_range_i,
  input  carry_t    carry_i,
  output carry_t    carry_o
);

  localparam logic [IDX_W_MAX-1:0] MyIdx = IDX_W_MAX'(CellIdx);

  task_state_e state_q, state_d;
  logic [7:0]  prio_q, prio_d;
  logic [31:0] wake_q, wake_d;
  carry_t      carry_q, carry_d;
  logic [31:0] diff;
  logic        eligible;

  assign diff     = cmd_i.value - wake_q;
  assign eligible = in_range_i && (state_q == TS_READY || state_q == TS_RUNNING);

  always_comb begin
    state_d = state_q;
    prio_d  = prio_q;
    wake_d  = wake_q;
    case (cmd_i.op)
      CELL_CREATE: begin
        if (cmd_i.target == MyIdx) begin
          state_d = TS_READY;
          prio_d  = cmd_i.prio;
          wake_d  = '0;
        end
      end
      CELL_WAKE: begin
        // wake when tick minus wake tick is not negative
        if (in_range_i && state_q == TS_BLOCKED && !diff[31]) begin
          state_d = TS_READY;
        end
      end
      CELL_BLOCK: begin
        if (cmd_i.target == MyIdx) begin
          state_d = TS_BLOCKED;
          wake_d  = cmd_i.value;
        end
      end
      CELL_APPLY: begin
        if (cmd_i.demote_en && cmd_i.demote == MyIdx && state_q == TS_RUNNING) begin
          state_d = TS_READY;
        end
        if (cmd_i.target == MyIdx) begin
          state_d = TS_RUNNING;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    carry_d = carry_i;
    if (eligible && (!carry_i.found || prio_q < carry_i.prio)) begin
      carry_d.found = 1'b1;
      carry_d.prio  = prio_q;
      carry_d.idx   = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    prio_q  <= prio_d;
    wake_q  <= wake_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

[design/priority_task_scheduler_with_delays_core.sv]
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | opcode, entry_present, priority_req, delay_ticks
// out     | output    | out_valid_o / out_ready_i | status, next_task, next_valid, switch_request,
//         |           |                           | current_task, current_valid
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (idle priority)
//
// create, switch and ignored words go from the exec state straight to output; a start, delay
// or tick that is not ignored also runs scan and apply for the best-candidate pass along the row
// one item is in work at a time; the next word is taken once the result is registered
// a stalled output holds the finished word, and the next item stops only at its own writeback
// reset clears the counters, flags and control; table entries are written before they are read
module priority_task_scheduler_with_delays_core import pts_pkg::*; #(
  parameter int unsigned MaxTasks = MAX_TASKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic        entry_present_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] delay_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  next_task_o,
  output logic        next_valid_o,
  output logic        switch_request_o,
  output logic [3:0]  current_task_o,
  output logic        current_valid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxTasks);
  localparam logic [IdxW-1:0] ScanLast = IdxW'(MaxTasks - 1);

  fsm_e            fsm_q, fsm_d;
  logic [2:0]      op_q, op_d;
  logic            entry_q, entry_d;
  logic [7:0]      prio_q, prio_d;
  logic [31:0]     delay_q, delay_d;
  logic [7:0]      idle_prio_q;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     tick_q, tick_d;
  logic            started_q, started_d;
  logic [IdxW-1:0] cur_q, cur_d, nxt_q, nxt_d;
  logic            cur_pres_q, cur_pres_d, nxt_pres_q, nxt_pres_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [1:0]      status_q, status_d;
  logic            sw_q, sw_d;
  logic            ov_q, ov_d;
  logic [1:0]      o_status_q, o_status_d;
  logic [3:0]      o_next_q, o_next_d, o_cur_q, o_cur_d;
  logic            o_nv_q, o_nv_d, o_cv_q, o_cv_d, o_sw_q, o_sw_d;
  cell_cmd_t       cmd;
  carry_t          carry [MaxTasks+1];
  carry_t          best;
  logic [IDX_W_MAX-1:0] nxt_wide, cur_wide;

  assign carry[0] = '0;
  assign best     = carry[MaxTasks];

  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    pts_cell #(.CellIdx(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .in_range_i (CntW'(g) < count_q),
      .carry_i    (carry[g]),
      .carry_o    (carry[g+1])
    );
  end

  assign in_ready_o  = (fsm_q == FSM_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    fsm_d      = fsm_q;
    op_d       = op_q;
    entry_d    = entry_q;
    prio_d     = prio_q;
    delay_d    = delay_q;
    count_d    = count_q;
    tick_d     = tick_q;
    started_d  = started_q;
    cur_d      = cur_q;
    cur_pres_d = cur_pres_q;
    nxt_d      = nxt_q;
    nxt_pres_d = nxt_pres_q;
    scan_d     = scan_q;
    status_d   = status_q;
    sw_d       = sw_q;
    ov_d       = ov_q && !out_ready_i;
    o_status_d = o_status_q;
    o_next_d   = o_next_q;
    o_nv_d     = o_nv_q;
    o_sw_d     = o_sw_q;
    o_cur_d    = o_cur_q;
    o_cv_d     = o_cv_q;
    nxt_wide   = IDX_W_MAX'(nxt_q);
    cur_wide   = IDX_W_MAX'(cur_q);
    cmd        = '0;
    cmd.op     = CELL_NOP;

    case (fsm_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          entry_d = entry_present_i;
          prio_d  = priority_req_i;
          delay_d = delay_ticks_i;
          fsm_d   = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        status_d = ST_IGNORED;
        sw_d     = 1'b0;
        scan_d   = '0;
        fsm_d    = FSM_OUT;
        case (op_q)
          OP_CREATE: begin
            if (!entry_q) begin
              status_d = ST_PARAM;
            end else if (count_q == CntMax) begin
              status_d = ST_FULL;
            end else begin
              cmd.op     = CELL_CREATE;
              cmd.target = IDX_W_MAX'(count_q);
              cmd.prio   = prio_q;
              count_d    = count_q + 1'b1;
              status_d   = ST_OK;
            end
          end
          OP_START: begin
            if (!started_q) begin
              started_d = 1'b1;
              fsm_d     = FSM_SCAN;
              if (count_q == CntMax) begin
                status_d = ST_FULL;
              end else begin
                cmd.op     = CELL_CREATE;
                cmd.target = IDX_W_MAX'(count_q);
                cmd.prio   = idle_prio_q;
                count_d    = count_q + 1'b1;
                status_d   = ST_OK;
              end
            end
          end
          OP_DELAY: begin
            if (delay_q != '0 && started_q && cur_pres_q) begin
              cmd.op     = CELL_BLOCK;
              cmd.target = cur_wide;
              cmd.value  = tick_q + delay_q;
              sw_d       = 1'b1;
              status_d   = ST_OK;
              fsm_d      = FSM_SCAN;
            end
          end
          OP_TICK: begin
            if (started_q) begin
              tick_d    = tick_q + 32'd1;
              cmd.op    = CELL_WAKE;
              cmd.value = tick_q + 32'd1;
              status_d  = ST_OK;
              fsm_d     = FSM_SCAN;
            end
          end
          OP_SWITCH: begin
            if (started_q) begin
              cur_d      = nxt_q;
              cur_pres_d = nxt_pres_q;
              status_d   = ST_OK;
            end
          end
          default: ;
        endcase
      end
      FSM_SCAN: begin
        // the candidate passes through the carry register of every cell to reach the end of the row
        scan_d = scan_q + 1'b1;
        if (scan_q == ScanLast) begin
          fsm_d = FSM_APPLY;
        end
      end
      FSM_APPLY: begin
        if (best.found) begin
          cmd.op        = CELL_APPLY;
          cmd.target    = best.idx;
          cmd.demote_en = cur_pres_q;
          cmd.demote    = cur_wide;
          nxt_d         = best.idx[IdxW-1:0];
          nxt_pres_d    = 1'b1;
        end
        if (op_q == OP_START) begin
          cur_d      = nxt_d;
          cur_pres_d = nxt_pres_d;
        end else if (op_q == OP_TICK) begin
          sw_d = (nxt_pres_d != cur_pres_q) || (nxt_pres_d && nxt_d != cur_q);
        end
        fsm_d = FSM_OUT;
      end
      FSM_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_next_d   = nxt_pres_q ? nxt_wide[3:0] : 4'd0;
          o_nv_d     = nxt_pres_q;
          o_sw_d     = sw_q;
          o_cur_d    = cur_pres_q ? cur_wide[3:0] : 4'd0;
          o_cv_d     = cur_pres_q;
          fsm_d      = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      idle_prio_q <= 8'd255;
      count_q     <= '0;
      tick_q      <= '0;
      started_q   <= 1'b0;
      cur_q       <= '0;
      cur_pres_q  <= 1'b0;
      nxt_q       <= '0;
      nxt_pres_q  <= 1'b0;
      scan_q      <= '0;
      ov_q        <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      if (cfg_valid_i) begin
        idle_prio_q <= cfg_data_i;
      end
      count_q    <= count_d;
      tick_q     <= tick_d;
      started_q  <= started_d;
      cur_q      <= cur_d;
      cur_pres_q <= cur_pres_d;
      nxt_q      <= nxt_d;
      nxt_pres_q <= nxt_pres_d;
      scan_q     <= scan_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    entry_q    <= entry_d;
    prio_q     <= prio_d;
    delay_q    <= delay_d;
    status_q   <= status_d;
    sw_q       <= sw_d;
    o_status_q <= o_status_d;
    o_next_q   <= o_next_d;
    o_nv_q     <= o_nv_d;
    o_sw_q     <= o_sw_d;
    o_cur_q    <= o_cur_d;
    o_cv_q     <= o_cv_d;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = o_status_q;
  assign next_task_o      = o_next_q;
  assign next_valid_o     = o_nv_q;
  assign switch_request_o = o_sw_q;
  assign current_task_o   = o_cur_q;
  assign current_valid_o  = o_cv_q;

endmodule

[design/pts_checker.sv]
module pts_checker import pts_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [3:0] next_task_o,
  input logic       next_valid_o,
  input logic       switch_request_o,
  input logic [3:0] current_task_o,
  input logic       current_valid_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(next_task_o) && $stable(current_task_o))
    else $error("stalled result changed");

  // one word in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a switch request only comes with a successful delay or tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switch_request_o |-> status_o == ST_OK)
    else $error("switch request with non-ok status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !next_valid_o |-> next_task_o == 4'd0 && !current_valid_o)
    else $error("current without next or stray next index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !current_valid_o |-> current_task_o == 4'd0)
    else $error("stray current index");

endmodule

bind priority_task_scheduler_with_delays_core pts_checker u_pts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .next_task_o      (next_task_o),
  .next_valid_o     (next_valid_o),
  .switch_request_o (switch_request_o),
  .current_task_o   (current_task_o),
  .current_valid_o  (current_valid_o)
);
